// File: design/bbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bbd_pkg;

  localparam int unsigned MaxWidthDef  = 2048;
  localparam int unsigned MaxHeightDef = 2048;
  localparam int unsigned ResetWidth   = 640;
  localparam int unsigned ResetHeight  = 480;

  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 12;

  localparam logic [CfgIdxW-1:0] CFG_IMAGE_WIDTH  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_HEIGHT = CfgIdxW'(1);

  // Neighbor sum and how many neighbors went into it.
  typedef struct packed {
    logic [9:0] sum;
    logic [2:0] cnt;
  } chan_t;

  function automatic int unsigned clamp_size(logic [CfgDataW-1:0] v, int unsigned hi);
    int unsigned x;
    x = int'(v);
    if (x < 2) begin
      return 2;
    end else if (x > hi) begin
      return hi;
    end
    return x;
  endfunction

  // Truncated mean for one to four neighbors; divide by 3 as multiply by 683 >> 11.
  function automatic logic [7:0] mean_of(chan_t c);
    logic [19:0] prod;
    logic [7:0]  res;
    prod = 20'(c.sum) * 20'd683;
    unique case (c.cnt)
      3'd1:    res = c.sum[7:0];
      3'd2:    res = c.sum[8:1];
      3'd3:    res = prod[18:11];
      3'd4:    res = c.sum[9:2];
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage
`default_nettype wire

// File: design/bbd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module bbd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// File: design/bayer_bilinear_demosaic.sv
`timescale 1ns / 1ps
`default_nettype none
// Bilinear demosaic of a GBRG raster stream: one raw 8-bit sample per transaction in,
// one RGB pixel per site out, one transaction per clock sustained unless the output
// stalls. Two line stores (single-port-read block RAMs, registered read) feed a 3x3
// window; a pixel leaves after the sample one row and one column beyond it has arrived,
// so after the last sample of a frame send width+1 flush transactions (tuser=1) to
// drain it. tuser=1 before the frame is complete is a bubble. A write to the width or
// height register restarts the frame.
module bayer_bilinear_demosaic
  import bbd_pkg::*;
#(
  parameter int unsigned MaxWidth  = MaxWidthDef,
  parameter int unsigned MaxHeight = MaxHeightDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [7:0]          s_axis_tdata,   // raw_value
  input  wire logic                s_axis_tuser,   // pad
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic      [23:0]         m_axis_tdata,   // red, green, blue
  output logic                     m_axis_tlast    // end_of_frame
);

  localparam int unsigned AW  = $clog2(MaxWidth);
  localparam int unsigned WW  = $clog2(MaxWidth + 1);
  localparam int unsigned RW  = $clog2(MaxHeight);
  localparam int unsigned HW  = $clog2(MaxHeight + 1);

  logic [WW-1:0] w_q;
  logic [HW-1:0] h_q;
  logic [AW-1:0] col_q, col_d;
  logic [HW-1:0] row_q, row_d;
  logic [AW-1:0] ocol_q, ocol_d;
  logic [RW-1:0] orow_q, orow_d;

  logic [7:0] up_rd, mid_rd;
  logic [7:0] c1_q [3], c2_q [3];
  logic [7:0] r_col [3];

  logic cfg_wr, acc, flush, active, emit, eof, col_wrap;
  logic a_adv, b_adv;

  logic  a_vld_q, a_eof_q;
  chan_t a_red_q, a_grn_q, a_blu_q;
  chan_t red_c, grn_c, blu_c, hz_c, vt_c, cr_c, dg_c, own_c;
  logic  vu, vd, vl, vr;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  assign b_adv         = !m_axis_tvalid || m_axis_tready;
  assign a_adv         = !a_vld_q || b_adv;
  assign s_axis_tready = a_adv;
  assign acc           = s_axis_tvalid && s_axis_tready;

  assign flush    = (row_q == h_q);
  assign active   = acc && (flush || !s_axis_tuser);
  assign emit     = active && (flush || row_q >= HW'(2) || (row_q == HW'(1) && col_q != '0));
  assign eof      = (HW'(orow_q) == h_q - HW'(1)) && (WW'(ocol_q) == w_q - WW'(1));
  assign col_wrap = (WW'(col_q) == w_q - WW'(1));

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    ocol_d = ocol_q;
    orow_d = orow_q;
    if (active) begin
      if (col_wrap) begin
        col_d = '0;
        if (!flush) begin
          row_d = row_q + HW'(1);
        end
      end else begin
        col_d = col_q + AW'(1);
      end
    end
    if (emit) begin
      if (eof) begin
        col_d  = '0;
        row_d  = '0;
        ocol_d = '0;
        orow_d = '0;
      end else if (WW'(ocol_q) == w_q - WW'(1)) begin
        ocol_d = '0;
        orow_d = orow_q + RW'(1);
      end else begin
        ocol_d = ocol_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q    <= WW'(clamp_size(CfgDataW'(ResetWidth), MaxWidth));
      h_q    <= HW'(clamp_size(CfgDataW'(ResetHeight), MaxHeight));
      col_q  <= '0;
      row_q  <= '0;
      ocol_q <= '0;
      orow_q <= '0;
    end else if (cfg_wr && (cfg_index_i == CFG_IMAGE_WIDTH ||
                            cfg_index_i == CFG_IMAGE_HEIGHT)) begin
      if (cfg_index_i == CFG_IMAGE_WIDTH) begin
        w_q <= WW'(clamp_size(cfg_data_i, MaxWidth));
      end else begin
        h_q <= HW'(clamp_size(cfg_data_i, MaxHeight));
      end
      col_q  <= '0;
      row_q  <= '0;
      ocol_q <= '0;
      orow_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      ocol_q <= ocol_d;
      orow_q <= orow_d;
    end
  end

  bbd_ram #(.Width(8), .Depth(MaxWidth)) u_upper (
    .clk_i   (clk_i),
    .we_i    (active),
    .waddr_i (col_q),
    .wdata_i (mid_rd),
    .raddr_i (col_d),
    .rdata_o (up_rd)
  );

  bbd_ram #(.Width(8), .Depth(MaxWidth)) u_middle (
    .clk_i   (clk_i),
    .we_i    (active),
    .waddr_i (col_q),
    .wdata_i (s_axis_tdata),
    .raddr_i (col_d),
    .rdata_o (mid_rd)
  );

  assign r_col[0] = up_rd;
  assign r_col[1] = mid_rd;
  assign r_col[2] = s_axis_tdata;

  always_ff @(posedge clk_i) begin
    if (active) begin
      for (int i = 0; i < 3; i++) begin
        c1_q[i] <= c2_q[i];
        c2_q[i] <= r_col[i];
      end
    end
  end

  // Window before the shift: c1_q left, c2_q center, r_col right; index 0 is the row above.
  assign vu = (orow_q != '0);
  assign vd = (HW'(orow_q) != h_q - HW'(1));
  assign vl = (ocol_q != '0);
  assign vr = (WW'(ocol_q) != w_q - WW'(1));

  always_comb begin
    hz_c.sum = (vl ? 10'(c1_q[1]) : 10'd0) + (vr ? 10'(r_col[1]) : 10'd0);
    hz_c.cnt = 3'(vl) + 3'(vr);
    vt_c.sum = (vu ? 10'(c2_q[0]) : 10'd0) + (vd ? 10'(c2_q[2]) : 10'd0);
    vt_c.cnt = 3'(vu) + 3'(vd);
    cr_c.sum = hz_c.sum + vt_c.sum;
    cr_c.cnt = hz_c.cnt + vt_c.cnt;
    dg_c.sum = ((vu && vl) ? 10'(c1_q[0]) : 10'd0) + ((vu && vr) ? 10'(r_col[0]) : 10'd0) +
               ((vd && vl) ? 10'(c1_q[2]) : 10'd0) + ((vd && vr) ? 10'(r_col[2]) : 10'd0);
    dg_c.cnt = 3'(vu && vl) + 3'(vu && vr) + 3'(vd && vl) + 3'(vd && vr);
    own_c.sum = 10'(c2_q[1]);
    own_c.cnt = 3'd1;
    unique case ({orow_q[0], ocol_q[0]})
      2'b00: begin
        grn_c = own_c; red_c = vt_c; blu_c = hz_c;
      end
      2'b01: begin
        blu_c = own_c; red_c = dg_c; grn_c = cr_c;
      end
      2'b10: begin
        red_c = own_c; blu_c = dg_c; grn_c = cr_c;
      end
      default: begin
        grn_c = own_c; red_c = hz_c; blu_c = vt_c;
      end
    endcase
  end

  // Two-stage output pipeline: neighbor sums, then means.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (a_adv) begin
        a_vld_q <= emit;
      end
      if (b_adv) begin
        m_axis_tvalid <= a_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv && emit) begin
      a_red_q <= red_c;
      a_grn_q <= grn_c;
      a_blu_q <= blu_c;
      a_eof_q <= eof;
    end
    if (b_adv && a_vld_q) begin
      m_axis_tdata <= {mean_of(a_blu_q), mean_of(a_grn_q), mean_of(a_red_q)};
      m_axis_tlast <= a_eof_q;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) WW'(col_q) < w_q)
    else $error("input column beyond width");
  assert property (@(posedge clk_i) disable iff (!rst_ni) row_q <= h_q)
    else $error("input row beyond flush row");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   HW'(orow_q) < h_q && WW'(ocol_q) < w_q)
    else $error("output position outside frame");
  assert property (@(posedge clk_i) disable iff (!rst_ni) emit && eof |=> row_q == '0)
    else $error("frame did not restart after last pixel");

endmodule
`default_nettype wire
